>>> sv/assert_macros.svh
// Assertion macros used by the RTL of the maximal rectangle block.
// Expects signals named clk and rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/mrect_pkg.sv
// Package for the maximal rectangle block: defaults, field widths and sequencer states.
// Used by max_rectangle_of_ones and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mrect_pkg;

  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 1024;

  localparam int ROW_W       = 64;
  localparam int CFG_W       = 7;
  localparam int AREA_W      = 17;
  localparam int OUT_TDATA_W = 24;

  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_FWD_END,
    ST_BWD,
    ST_BWD_END,
    ST_CMP_END,
    ST_DONE
  } mrect_state_t;

endpackage

`default_nettype wire

>>> sv/max_rectangle_of_ones.sv
// Maximal all-ones rectangle over a binary matrix streamed one row per request.
// Depends on mrect_pkg, mrect_ram and assert_macros.svh.
//
// Each request on the slave stream carries one matrix row in s_tdata, with s_tlast set on
// the final row of a matrix; each row produces one result on the master stream with the best
// rectangle area so far, and m_tlast set when it answers a finished matrix, after which the
// matrix state is back at its reset values. Per column the height, left bound and right bound
// sit in a single-port-read RAM that one shared column unit walks forward and then backward
// over the N columns in use; s_tready is low from acceptance until the result is loaded into
// the output register. A finished result waits in the output register while the next row is
// taken. Per-column valid bits give the reset values, so no clearing pass follows reset, a
// configuration write or the final row. Writing cfg_data sets the column count (0 acts as 1,
// values above MAX_COLS act as MAX_COLS) and clears the matrix state.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module max_rectangle_of_ones
  import mrect_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_W-1:0]       cfg_data,   // columns_in_use [6:0]
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [ROW_W-1:0]       s_tdata,    // row_bits [63:0]
  input  wire logic                   s_tlast,    // last_row
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [OUT_TDATA_W-1:0] m_tdata,    // best_area [16:0], zeros above
  output logic                        m_tlast     // final_res
);

  localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int HW  = $clog2(MAX_ROWS + 1);
  localparam int EW  = HW + CW + CW;
  localparam int PW  = CW + HW;
  localparam int PXW = (PW > AREA_W) ? PW : AREA_W;

  mrect_state_t state, state_next;

  logic [CW-1:0]       cols_n;
  logic [ROW_W-1:0]    row;
  logic                row_last;
  logic [AW-1:0]       idx;
  logic [CW-1:0]       cur_left;
  logic [CW-1:0]       cur_right;
  logic                p1_vld;
  logic                p1_bwd;
  logic [AW-1:0]       p1_idx;
  logic                p2_vld;
  logic [PW-1:0]       p2_prod;
  logic [AREA_W-1:0]   best;
  logic [MAX_COLS-1:0] colv;
  logic                out_valid;
  logic [AREA_W-1:0]   out_area;
  logic                out_last;

  logic                s_accept;
  logic                cfg_accept;
  logic                rd_issue;
  logic                out_load;
  logic [AW-1:0]       last_idx;
  logic [CW-1:0]       cfg_eff;

  logic [EW-1:0]       rd_data;
  logic [EW-1:0]       wr_data;
  logic                col_ok;
  logic                bit_set;
  logic [HW-1:0]       e_h;
  logic [CW-1:0]       e_l;
  logic [CW-1:0]       e_r;
  logic [HW-1:0]       new_h;
  logic [CW-1:0]       new_l;
  logic [CW-1:0]       new_r;
  logic [CW-1:0]       diff;
  logic [PXW-1:0]      prod_x;
  logic [AREA_W-1:0]   area_sat;

  assign last_idx   = AW'(cols_n - CW'(1));
  assign s_accept   = s_tvalid && s_tready;
  assign cfg_accept = cfg_valid && cfg_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (s_accept) state_next = ST_FWD;
      ST_FWD:     if (idx == last_idx) state_next = ST_FWD_END;
      ST_FWD_END: state_next = ST_BWD;
      ST_BWD:     if (idx == '0) state_next = ST_BWD_END;
      ST_BWD_END: state_next = ST_CMP_END;
      ST_CMP_END: state_next = ST_DONE;
      ST_DONE:    if (out_load) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    cfg_ready = 1'b0;
    s_tready  = 1'b0;
    rd_issue  = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cfg_ready = 1'b1;
        s_tready  = !cfg_valid;
      end
      ST_FWD, ST_BWD: rd_issue = 1'b1;
      ST_DONE:        out_load = !out_valid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    if (cfg_data == '0) begin
      cfg_eff = CW'(1);
    end else if (cfg_data > CFG_W'(MAX_COLS)) begin
      cfg_eff = CW'(MAX_COLS);
    end else begin
      cfg_eff = CW'(cfg_data);
    end
  end

  // Column RAM: height, left bound, right bound.
  mrect_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_COLS)
  ) u_cols (
    .clk  (clk),
    .we   (p1_vld),
    .waddr(p1_idx),
    .wdata(wr_data),
    .raddr(idx),
    .rdata(rd_data)
  );

  // Shared column unit.
  always_comb begin
    col_ok  = colv[p1_idx];
    bit_set = row[p1_idx];
    e_h     = col_ok ? rd_data[EW-1 -: HW] : '0;
    e_l     = col_ok ? rd_data[2*CW-1 -: CW] : '0;
    e_r     = col_ok ? rd_data[CW-1:0] : cols_n;
    new_h   = e_h;
    new_l   = e_l;
    new_r   = e_r;
    if (!p1_bwd) begin
      if (bit_set) begin
        new_h = (e_h < HW'(MAX_ROWS)) ? e_h + HW'(1) : e_h;
        new_l = (cur_left > e_l) ? cur_left : e_l;
      end else begin
        new_h = '0;
        new_l = '0;
      end
    end else begin
      if (bit_set) begin
        new_r = (cur_right < e_r) ? cur_right : e_r;
      end else begin
        new_r = cols_n;
      end
    end
    diff    = (new_r > e_l) ? new_r - e_l : '0;
    wr_data = {new_h, new_l, new_r};
  end

  assign prod_x   = PXW'(p2_prod);
  assign area_sat = (prod_x > PXW'(AREA_MAX)) ? AREA_MAX : prod_x[AREA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_n <= CW'(MAX_COLS);
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      colv   <= '0;
      best   <= '0;
    end else begin
      p1_vld <= rd_issue;
      p2_vld <= p1_vld && p1_bwd;
      if (cfg_accept) begin
        cols_n <= cfg_eff;
        colv   <= '0;
        best   <= '0;
      end else if (out_load && row_last) begin
        colv <= '0;
        best <= '0;
      end else begin
        if (p1_vld && !p1_bwd) begin
          colv[p1_idx] <= 1'b1;
        end
        if (p2_vld && (area_sat > best)) begin
          best <= area_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      row       <= s_tdata;
      row_last  <= s_tlast;
      idx       <= '0;
      cur_left  <= '0;
      cur_right <= cols_n;
    end else begin
      unique case (state)
        ST_FWD:     idx <= idx + AW'(1);
        ST_FWD_END: idx <= last_idx;
        ST_BWD:     idx <= idx - AW'(1);
        default: ;
      endcase
      if (p1_vld && !bit_set) begin
        if (p1_bwd) begin
          cur_right <= CW'(p1_idx);
        end else begin
          cur_left <= CW'(p1_idx) + CW'(1);
        end
      end
    end
    p1_idx  <= idx;
    p1_bwd  <= (state == ST_BWD);
    p2_prod <= PW'(diff) * PW'(e_h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_area <= best;
      out_last <= row_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'(out_area);
  assign m_tlast  = out_last;

  `ASSERT_CLK(a_col_in_range, p1_vld |-> (CW'(p1_idx) < cols_n), "column beyond width")
  `ASSERT_CLK(a_busy_after_accept, s_accept |=> !s_tready, "row accepted while busy")
  `ASSERT_CLK(a_final_clears, (out_load && row_last) |=> (best == '0 && colv == '0), "not cleared")
  `ASSERT_ALWAYS(a_cmp_follows_bwd, p2_vld |-> (!rst && $past(p1_vld && p1_bwd)), "stray compare")

endmodule

`default_nettype wire

>>> sv/mrect_ram.sv
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mrect_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for max_rectangle_of_ones: streams binary matrices row by row
// and checks each best area against an in-bench model of column passes or, for typed
// steps, a tabled value. Depends on mrect_pkg and the max_rectangle_of_ones RTL only.
`timescale 1ns / 1ps

module testbench;
  import mrect_pkg::*;

  localparam int TOTAL_ROWS     = 1050;
  localparam int TALL_ROWS      = MAX_ROWS_DEF + 6;
  localparam int STALL_LIMIT    = 4000;
  localparam int HOLD_CYCLES    = 800;
  localparam int SETTLE_CYCLES  = 2 * MAX_COLS_DEF + 10;
  localparam logic [ROW_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic              fin;
  } area_result_t;

  typedef enum logic {STEP_ROW, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t        kind;
    logic [ROW_W-1:0]  bits;
    logic              last;
    logic              typed;
    logic [AREA_W-1:0] exp_area;
  } dir_step_t;

  // For a configuration step the column count sits in the low bits of bits.
  localparam dir_step_t DIRECTED [0:19] = '{
    '{STEP_ROW, 64'h0,                   1'b0, 1'b1, 17'd0},
    '{STEP_ROW, ALL_ONES,                1'b1, 1'b1, 17'd64},
    '{STEP_ROW, ALL_ONES,                1'b0, 1'b1, 17'd64},
    '{STEP_ROW, ALL_ONES,                1'b1, 1'b1, 17'd128},
    '{STEP_ROW, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 17'd0},
    '{STEP_ROW, 64'h5555_5555_5555_5555, 1'b1, 1'b0, 17'd0},
    '{STEP_ROW, 64'h0000_FFFF_FFFF_0000, 1'b0, 1'b0, 17'd0},
    '{STEP_ROW, 64'hFFFF_FFFF_0000_0000, 1'b1, 1'b0, 17'd0},
    '{STEP_ROW, 64'h8000_0000_0000_0000, 1'b1, 1'b1, 17'd1},
    '{STEP_ROW, 64'h0000_0000_0000_0001, 1'b1, 1'b1, 17'd1},
    '{STEP_CFG, 64'd0,                   1'b0, 1'b0, 17'd0},
    '{STEP_ROW, ALL_ONES,                1'b0, 1'b1, 17'd1},
    '{STEP_ROW, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1, 17'd1},
    '{STEP_CFG, 64'd127,                 1'b0, 1'b0, 17'd0},
    '{STEP_ROW, ALL_ONES,                1'b0, 1'b1, 17'd64},
    '{STEP_CFG, 64'd8,                   1'b0, 1'b0, 17'd0},
    '{STEP_ROW, ALL_ONES,                1'b1, 1'b1, 17'd8},
    '{STEP_CFG, 64'd64,                  1'b0, 1'b0, 17'd0},
    '{STEP_ROW, 64'h00FF_00FF_0F0F_3C3C, 1'b0, 1'b0, 17'd0},
    '{STEP_ROW, 64'hFFFF_00FF_0FFF_3C3C, 1'b1, 1'b0, 17'd0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [ROW_W-1:0]       s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  max_rectangle_of_ones i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state of the matrix
  logic [10:0]       col_height [MAX_COLS_DEF];
  logic [6:0]        col_left   [MAX_COLS_DEF];
  logic [6:0]        col_right  [MAX_COLS_DEF];
  logic [AREA_W-1:0] best_area_acc;
  logic [CFG_W-1:0]  width_reg;

  area_result_t pending_areas [$];
  int mismatches    = 0;
  int rows_sent     = 0;
  int matrices_done = 0;
  int cfg_writes    = 0;
  int results_seen  = 0;
  int idle_cycles   = 0;
  logic steady;

  assign steady = (rows_sent >= 500) && (rows_sent < 700);

  function automatic int unsigned active_columns();
    int unsigned n;
    n = width_reg;
    if (n < 1) n = 1;
    if (n > MAX_COLS_DEF) n = MAX_COLS_DEF;
    return n;
  endfunction

  function automatic void clear_matrix();
    for (int j = 0; j < MAX_COLS_DEF; j++) begin
      col_height[j] = '0;
      col_left[j]   = '0;
      col_right[j]  = 7'(active_columns());
    end
    best_area_acc = '0;
  endfunction

  function automatic area_result_t predict_row(input logic [ROW_W-1:0] bits, input logic last);
    int unsigned n, cur_left, cur_right, area;
    area_result_t res;
    n = active_columns();
    cur_left = 0;
    cur_right = n;
    for (int j = 0; j < n; j++) begin
      if (bits[j]) begin
        if (col_height[j] < MAX_ROWS_DEF) col_height[j] = col_height[j] + 1'b1;
        if (cur_left > col_left[j]) col_left[j] = 7'(cur_left);
      end else begin
        col_height[j] = '0;
        col_left[j] = '0;
        cur_left = j + 1;
      end
    end
    for (int j = n - 1; j >= 0; j--) begin
      if (bits[j]) begin
        if (cur_right < col_right[j]) col_right[j] = 7'(cur_right);
      end else begin
        col_right[j] = 7'(n);
        cur_right = j;
      end
      area = (col_right[j] > col_left[j]) ?
             (int'(col_right[j]) - int'(col_left[j])) * int'(col_height[j]) : 0;
      if (area > AREA_MAX) area = AREA_MAX;
      if (area > best_area_acc) best_area_acc = AREA_W'(area);
    end
    res.area = best_area_acc;
    res.fin = last;
    if (last) clear_matrix();
    return res;
  endfunction

  function automatic logic [ROW_W-1:0] random_row(input logic [ROW_W-1:0] prev);
    logic [ROW_W-1:0] a, b, c;
    int unsigned lo, hi;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    lo = $urandom_range(0, 63);
    hi = $urandom_range(lo, 63);
    case ($urandom_range(0, 5))
      0: return a;
      1: return a | b;
      2: return a | b | c;
      3: return ~(a & b & c);
      4: return prev ^ (a & b & c);
      default: return (ALL_ONES >> (63 - hi)) & (ALL_ONES << lo);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_width();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 7'd64;
      3: return 7'd1;
      4: return 7'($urandom_range(65, 126));
      default: return 7'($urandom_range(2, 63));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 100)
      $display("ERROR at %0t ns: %s is %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Ends on the rising edge at which the row request is taken.
  task automatic send_row(input logic [ROW_W-1:0] bits, input logic last,
                          input logic typed, input logic [AREA_W-1:0] typed_area);
    area_result_t want;
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 12) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= bits;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    want = predict_row(bits, last);
    if (typed) want.area = typed_area;
    pending_areas.push_back(want);
    rows_sent++;
    if (last) matrices_done++;
  endtask

  task automatic write_columns(input logic [CFG_W-1:0] value);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_areas.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    width_reg = value;
    clear_matrix();
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [ROW_W-1:0] row;
    int len;
    logic cut;
    width_reg = 7'd64;
    clear_matrix();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == STEP_CFG)
        write_columns(DIRECTED[i].bits[CFG_W-1:0]);
      else
        send_row(DIRECTED[i].bits, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].exp_area);
    end

    // A solid band in the low four columns drives the heights past saturation.
    write_columns(7'd6);
    for (int r = 0; r < TALL_ROWS; r++)
      send_row({$urandom, $urandom} | 64'hF, r == TALL_ROWS - 1, 1'b0, '0);

    row = '0;
    while (rows_sent < TOTAL_ROWS) begin
      if ($urandom_range(0, 3) == 0) write_columns(random_width());
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      cut = ($urandom_range(0, 9) == 0);
      for (int r = 0; r < len; r++) begin
        row = random_row(row);
        send_row(row, !cut && (r == len - 1), 1'b0, '0);
      end
      if (cut) write_columns(random_width());
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_areas.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d rows forming %0d complete matrices, with %0d column-count writes.",
             rows_sent, matrices_done, cfg_writes);
    $display("Checked %0d results, including a height-saturating matrix and two long stalls.",
             results_seen);
    if (mismatches == 0) begin
      $display("max_rectangle_of_ones: match");
    end else begin
      $display("max_rectangle_of_ones: mismatch");
    end
    $finish;
  end

  // Result side, with two long hold-offs so that the block backs up into its input.
  initial begin
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if ((holds_done == 0 && results_seen >= 300) || (holds_done == 1 && results_seen >= 800))
      begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (!steady && $urandom_range(0, 99) < 12) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    area_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_areas.size() == 0) begin
        report_mismatch("best_area of a result with no request pending", m_tdata, 0);
      end else begin
        want = pending_areas.pop_front();
        if (m_tdata[AREA_W-1:0] !== want.area)
          report_mismatch("best_area", m_tdata[AREA_W-1:0], want.area);
        if (m_tlast !== want.fin)
          report_mismatch("final_res", m_tlast, want.fin);
        if (m_tdata[OUT_TDATA_W-1:AREA_W] !== '0)
          report_mismatch("tdata padding", m_tdata[OUT_TDATA_W-1:AREA_W], 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: %0d cycles without any handshake.", idle_cycles);
        $display("max_rectangle_of_ones: mismatch");
        $finish;
      end
    end
  end

endmodule

>>> max_rectangle_of_ones.f
+incdir+sv
sv/mrect_pkg.sv
sv/mrect_ram.sv
sv/max_rectangle_of_ones.sv
tb/sv/testbench.sv
